@@ rtl/core/motion_input_debounce_tracker_macros.svh @@
// Assertion helpers shared by the motion tracker RTL.
`ifndef MOTION_INPUT_DEBOUNCE_TRACKER_MACROS_SVH
`define MOTION_INPUT_DEBOUNCE_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MIDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motion tracker check failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define MIDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motion tracker check failed (next cycle)");

`endif

@@ rtl/core/midt_pkg.sv @@
`timescale 1ns / 1ps

package midt_pkg;

  localparam int CHANNELS   = 4;
  localparam int TIME_BITS  = 32;

  localparam int RAW_W      = 4;
  localparam int NOW_W      = 32;
  localparam int IDX_W      = 2;
  localparam int MASK_W     = 4;
  localparam int CNT_W      = 4;
  localparam int DUR_W      = 32;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [MASK_W-1:0] ENABLE_RESET   = 4'hF;
  localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = 4'd3;

  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK    = 2'd0,
    REG_DEBOUNCE_READS = 2'd1,
    REG_MOTION_TIMEOUT = 2'd2
  } cfg_reg_t;

  // Per-lane command for the accepted item.
  typedef struct packed {
    logic   sample;
    logic   query_hit;
    logic   raw_level;
    stamp_t now;
  } lane_cmd_t;

  // Stored state of one lane, as seen before the current item.
  typedef struct packed {
    logic   level;
    logic   rising;
    stamp_t start;
    stamp_t last;
  } lane_state_t;

  // What a lane found for the current sample.
  typedef struct packed {
    logic changed;
    logic mask_bit;
  } lane_flag_t;

  typedef struct packed {
    logic              any_changed;
    logic [MASK_W-1:0] motion_mask;
    logic              any_motion;
    logic              channel_motion;
    logic              channel_rising;
    logic [DUR_W-1:0]  motion_duration_ms;
    logic              timed_out;
  } result_t;

endpackage

@@ rtl/core/midt_lane.sv @@
`timescale 1ns / 1ps

module midt_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  midt_pkg::lane_cmd_t            cmd,
  input  logic                           enable,
  input  logic [midt_pkg::CNT_W-1:0]     need,
  output midt_pkg::lane_state_t          state,
  output midt_pkg::lane_flag_t           flag
);
  import midt_pkg::*;

  logic             level_r, level_nxt;
  logic             rising_r, rising_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  stamp_t           start_r, start_nxt;
  stamp_t           last_r, last_nxt;
  logic [CNT_W-1:0] cnt_step;
  logic             level_new;

  always_comb begin
    level_nxt  = level_r;
    rising_nxt = rising_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    last_nxt   = last_r;
    flag       = '0;
    cnt_step   = '0;
    level_new  = level_r;
    if (cmd.sample && enable) begin
      cnt_step = (cmd.raw_level != level_r) ? cnt_r + CNT_W'(1) : '0;
      if (cnt_step >= need) begin
        // A rise opens a new motion episode.
        if (cmd.raw_level && !level_r) begin
          rising_nxt = 1'b1;
          start_nxt  = cmd.now;
        end
        level_new    = cmd.raw_level;
        cnt_step     = '0;
        flag.changed = 1'b1;
      end
      cnt_nxt   = cnt_step;
      level_nxt = level_new;
      if (level_new) begin
        last_nxt = cmd.now;
      end
      flag.mask_bit = level_new;
    end else if (cmd.query_hit) begin
      rising_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 1'b0;
      rising_r <= 1'b0;
      cnt_r    <= '0;
      start_r  <= '0;
      last_r   <= '0;
    end else begin
      level_r  <= level_nxt;
      rising_r <= rising_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      last_r   <= last_nxt;
    end
  end

  assign state.level  = level_r;
  assign state.rising = rising_r;
  assign state.start  = start_r;
  assign state.last   = last_r;

endmodule

@@ rtl/core/midt_merge.sv @@
`timescale 1ns / 1ps

module midt_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            acc,
  input  midt_pkg::item_kind_t                            kind,
  input  logic [midt_pkg::IDX_W-1:0]                      sensor_index,
  input  midt_pkg::stamp_t                                now,
  input  logic [midt_pkg::TIMEOUT_W-1:0]                  timeout,
  input  midt_pkg::lane_state_t [midt_pkg::CHANNELS-1:0]  lane_state,
  input  midt_pkg::lane_flag_t  [midt_pkg::CHANNELS-1:0]  lane_flag,
  output midt_pkg::result_t                               res
);
  import midt_pkg::*;

  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [CHANNELS-1:0] mask_vec;
  logic [CHANNELS-1:0] changed_vec;
  logic [MASK_W-1:0]   new_mask;
  lane_state_t         sel;
  logic                hit;
  stamp_t              diff_start;
  stamp_t              diff_last;

  always_comb begin
    sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      mask_vec[i]    = lane_flag[i].mask_bit;
      changed_vec[i] = lane_flag[i].changed;
      if (int'(sensor_index) == i) begin
        sel = lane_state[i];
      end
    end
  end

  assign hit        = int'(sensor_index) < CHANNELS;
  assign new_mask   = MASK_W'(mask_vec);
  assign diff_start = now - sel.start;
  assign diff_last  = now - sel.last;
  assign mask_nxt   = (acc && kind == KIND_SAMPLE) ? new_mask : mask_r;

  always_comb begin
    res = '0;
    if (kind == KIND_SAMPLE) begin
      res.any_changed = |changed_vec;
      res.motion_mask = new_mask;
    end else begin
      res.motion_mask = mask_r;
      if (hit) begin
        res.channel_motion = sel.level;
        res.channel_rising = sel.rising;
        if (sel.level) begin
          res.motion_duration_ms = DUR_W'(diff_start);
        end else begin
          res.timed_out = 64'(diff_last) >= 64'(timeout);
        end
      end else begin
        res.timed_out = 1'b1;
      end
    end
    res.any_motion = |res.motion_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

@@ rtl/core/motion_input_debounce_tracker.sv @@
`timescale 1ns / 1ps
`include "motion_input_debounce_tracker_macros.svh"
// Debounce and motion tracking for four motion-sensor inputs.
// Input channel (in_*): each request is a sample (in_tuser = 0) carrying the raw
// pin levels and the current millisecond time, or a query (in_tuser = 1) naming
// one channel. Every request produces exactly one result request on out_*.
// Configuration channel (cfg_*): enable mask, debounce count and idle timeout.
// It is always ready; write it only while no requests are in flight.
// Results are registered in the output register, or in the skid register
// while the receiver stalls. Throughput: one request per cycle unless the skid
// register is full. Each sensor has its own lane that updates its counter,
// level and time stamps; a merge stage builds the result in the accepting cycle.
// Stalls: results sit in an output register backed by a one-entry skid
// register, so a request is still accepted in the cycle the receiver first
// stalls; in_tready drops only once the skid register holds a result.
// Reset: synchronous, active low. All lane state clears, the enable mask
// returns to all channels, the debounce count to three and the timeout to
// zero. No clearing pass is needed after reset.
module motion_input_debounce_tracker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [3:0] raw_levels, [35:4] now_ms, [37:36] sensor_index, [39:38] zero
  input  logic [midt_pkg::IN_DATA_W-1:0]        in_tdata,
  // [0] kind
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] any_changed, [4:1] motion_mask, [5] any_motion, [6] channel_motion,
  // [7] channel_rising, [39:8] motion_duration_ms, [40] timed_out, [47:41] zero
  output logic [midt_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [midt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [midt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import midt_pkg::*;

  // Configuration registers.
  logic [MASK_W-1:0]    enable_r;
  logic [CNT_W-1:0]     debounce_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [CNT_W-1:0]     need;

  // Unpacked request fields.
  logic [RAW_W-1:0]     raw_levels;
  logic [NOW_W-1:0]     now_ms;
  logic [IDX_W-1:0]     sensor_index;
  item_kind_t           kind;
  stamp_t               now_t;
  logic [CHANNELS-1:0]  raw_ext;
  logic [CHANNELS-1:0]  enable_ext;
  logic                 acc;

  lane_cmd_t   [CHANNELS-1:0] lane_cmd;
  lane_state_t [CHANNELS-1:0] lane_state;
  lane_flag_t  [CHANNELS-1:0] lane_flag;
  logic        [CHANNELS-1:0] query_hit;
  logic        [CHANNELS-1:0] rising_vec;
  result_t                    res;

  // Output register and skid register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [OUT_DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic [OUT_DATA_W-1:0] res_data;

  assign raw_levels   = in_tdata[3:0];
  assign now_ms       = in_tdata[35:4];
  assign sensor_index = in_tdata[37:36];
  assign kind         = item_kind_t'(in_tuser);
  assign now_t        = TIME_BITS'(now_ms);
  assign raw_ext      = CHANNELS'(raw_levels);
  assign enable_ext   = CHANNELS'(enable_r);

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;

  // A debounce count of zero behaves like one.
  assign need = (debounce_r == '0) ? CNT_W'(1) : debounce_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= ENABLE_RESET;
      debounce_r <= DEBOUNCE_RESET;
      timeout_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE_MASK:    enable_r   <= cfg_data[MASK_W-1:0];
        REG_DEBOUNCE_READS: debounce_r <= cfg_data[CNT_W-1:0];
        REG_MOTION_TIMEOUT: timeout_r  <= cfg_data[TIMEOUT_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Fan the accepted request out to the lanes.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      query_hit[i]          = acc && kind == KIND_QUERY && int'(sensor_index) == i;
      lane_cmd[i].sample    = acc && kind == KIND_SAMPLE;
      lane_cmd[i].query_hit = query_hit[i];
      lane_cmd[i].raw_level = raw_ext[i];
      lane_cmd[i].now       = now_t;
      rising_vec[i]         = lane_state[i].rising;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    midt_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd[g]),
      .enable (enable_ext[g]),
      .need   (need),
      .state  (lane_state[g]),
      .flag   (lane_flag[g])
    );
  end

  midt_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .kind         (kind),
    .sensor_index (sensor_index),
    .now          (now_t),
    .timeout      (timeout_r),
    .lane_state   (lane_state),
    .lane_flag    (lane_flag),
    .res          (res)
  );

  assign res_data = {7'd0, res.timed_out, res.motion_duration_ms, res.channel_rising,
                     res.channel_motion, res.any_motion, res.motion_mask, res.any_changed};

  // The output register drains first; the skid register only catches the
  // request accepted in the cycle the receiver stalls with a full output.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = acc;
        if (acc) begin
          out_data_nxt = res_data;
        end
      end
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A filled skid register always sits behind a filled output register.
  `MIDT_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  // An accepted request always leaves a valid result in the output register in the next cycle.
  `MIDT_ASSERT_NEXT(a_accept_gives_result, acc, out_valid_r)
  // A query clears the rising latch of the channel it names.
  `MIDT_ASSERT_NEXT(a_query_clears_rising, |query_hit,
                    (rising_vec & $past(query_hit)) == '0)
  // The any-motion flag of a delivered result agrees with its motion mask.
  `MIDT_ASSERT_NOW(a_any_motion_match, out_valid_r,
                   out_data_r[5] == (out_data_r[4:1] != '0))

endmodule

@@ test/tb_motion_input_debounce_tracker.sv @@
`timescale 1ns / 1ps

module tb_motion_input_debounce_tracker;
  import midt_pkg::*;

  // The run is cut off here no matter what state the block is in.
  localparam int CYCLE_LIMIT = 400000;

  // One request as the sender sees it, before it is packed onto in_tdata.
  typedef struct {
    item_kind_t        kind;
    logic [RAW_W-1:0]  raw;
    stamp_t            now;
    logic [IDX_W-1:0]  idx;
  } sensor_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [3:0] raw_levels, [35:4] now_ms, [37:36] sensor_index, [39:38] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] kind
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] any_changed, [4:1] motion_mask, [5] any_motion, [6] channel_motion,
  // [7] channel_rising, [39:8] motion_duration_ms, [40] timed_out, [47:41] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  motion_input_debounce_tracker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be sent, and the reports the tracker owes us, oldest first.
  sensor_req_t pending_requests_q[$];
  result_t     expected_reports_q[$];

  // Our own copy of the tracker: register settings and per-channel state.
  logic [MASK_W-1:0]    enable_cfg;
  logic [CNT_W-1:0]     debounce_cfg;
  logic [TIMEOUT_W-1:0] timeout_cfg;
  logic                 level_st [CHANNELS];
  logic [CNT_W-1:0]     miss_st  [CHANNELS];
  logic                 rise_st  [CHANNELS];
  stamp_t               start_st [CHANNELS];
  stamp_t               last_st  [CHANNELS];
  logic [MASK_W-1:0]    mask_st;

  int  error_count = 0;
  int  checked_count = 0;
  int  sample_count = 0;
  int  query_count = 0;
  int  cfg_count = 0;
  int  cycle_count = 0;
  // Set at the rising edge when the request on the input channel was taken.
  logic req_taken = 1'b0;

  // Models one request. Samples run every enabled channel through its
  // mismatch counter; queries read one channel and clear its rising flag.
  task automatic track_motion(input sensor_req_t req, output result_t rep);
    logic [CNT_W-1:0]  need;
    logic [MASK_W-1:0] mask_now;
    logic              lvl;
    int                ch;
    rep = '0;
    if (req.kind == KIND_SAMPLE) begin
      // A debounce count of zero behaves like one.
      need = (debounce_cfg == '0) ? CNT_W'(1) : debounce_cfg;
      mask_now = '0;
      for (ch = 0; ch < CHANNELS; ch++) begin
        // Disabled channels keep their state frozen and stay out of the mask.
        if (enable_cfg[ch]) begin
          lvl = req.raw[ch];
          if (lvl != level_st[ch]) miss_st[ch] = miss_st[ch] + 1'b1;
          else miss_st[ch] = '0;
          if (miss_st[ch] >= need) begin
            if (lvl && !level_st[ch]) begin
              rise_st[ch]  = 1'b1;
              start_st[ch] = req.now;
              last_st[ch]  = req.now;
            end
            level_st[ch] = lvl;
            miss_st[ch] = '0;
            rep.any_changed = 1'b1;
          end
          if (level_st[ch]) begin
            mask_now[ch] = 1'b1;
            last_st[ch] = req.now;
          end
        end
      end
      mask_st = mask_now;
    end else begin
      // A disabled channel answers from whatever it held when it was disabled.
      rep.channel_motion = level_st[req.idx];
      rep.channel_rising = rise_st[req.idx];
      rise_st[req.idx] = 1'b0;
      if (level_st[req.idx]) begin
        rep.motion_duration_ms = req.now - start_st[req.idx];
      end else begin
        rep.timed_out = (stamp_t'(req.now - last_st[req.idx]) >= timeout_cfg);
      end
    end
    rep.motion_mask = mask_st;
    rep.any_motion = |mask_st;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Everything that happens at a rising edge is handled here, in a fixed
  // order: register writes, then the finished report, then the new request.
  // Because reports are registered, a report can never belong to a request taken
  // at the same edge, so this order is safe.
  always @(posedge clk) begin : edge_monitor
    sensor_req_t req;
    result_t     want;
    result_t     got;
    int          ch;
    req_taken = 1'b0;
    if (!rst_n) begin
      enable_cfg   = ENABLE_RESET;
      debounce_cfg = DEBOUNCE_RESET;
      timeout_cfg  = '0;
      for (ch = 0; ch < CHANNELS; ch++) begin
        level_st[ch] = 1'b0;
        miss_st[ch]  = '0;
        rise_st[ch]  = 1'b0;
        start_st[ch] = '0;
        last_st[ch]  = '0;
      end
      mask_st = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ENABLE_MASK:    enable_cfg   = cfg_data[MASK_W-1:0];
          REG_DEBOUNCE_READS: debounce_cfg = cfg_data[CNT_W-1:0];
          REG_MOTION_TIMEOUT: timeout_cfg  = cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
        cfg_count++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports_q.size() == 0) begin
          $error("report arrived with none outstanding: 0x%0h", out_tdata);
          error_count++;
        end else begin
          want = expected_reports_q.pop_front();
          got.any_changed        = out_tdata[0];
          got.motion_mask        = out_tdata[4:1];
          got.any_motion         = out_tdata[5];
          got.channel_motion     = out_tdata[6];
          got.channel_rising     = out_tdata[7];
          got.motion_duration_ms = out_tdata[39:8];
          got.timed_out          = out_tdata[40];
          check_field("any_changed", want.any_changed, got.any_changed);
          check_field("motion_mask", want.motion_mask, got.motion_mask);
          check_field("any_motion", want.any_motion, got.any_motion);
          check_field("channel_motion", want.channel_motion, got.channel_motion);
          check_field("channel_rising", want.channel_rising, got.channel_rising);
          check_field("motion_duration_ms", want.motion_duration_ms,
                      got.motion_duration_ms);
          check_field("timed_out", want.timed_out, got.timed_out);
          check_field("padding", '0, out_tdata[47:41]);
          checked_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        req = pending_requests_q.pop_front();
        track_motion(req, want);
        expected_reports_q.push_back(want);
        if (req.kind == KIND_SAMPLE) sample_count++;
        else query_count++;
        req_taken = 1'b1;
      end
    end
  end

  // Sender: presents the oldest pending request, holds it until it is taken,
  // and works in bursts of random length separated by random gaps. A burst
  // of up to 60 requests with no gap after it gives stretches of full rate.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !req_taken) begin
      // Request still waiting for in_tready; keep it on the bus.
    end else if (gap_left != 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (pending_requests_q.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tuser  <= pending_requests_q[0].kind;
      in_tdata  <= {2'b00, pending_requests_q[0].idx, pending_requests_q[0].now,
                    pending_requests_q[0].raw};
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left--;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: each stretch of random length picks how often it is ready,
  // from always ready down to stalling most of the time.
  int ready_span = 0;
  int ready_pct = 100;

  always @(negedge clk) begin
    if (ready_span == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 50;
        default: ready_pct = 20;
      endcase
      ready_span = $urandom_range(8, 40);
    end
    ready_span--;
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_request(input item_kind_t kind, input logic [RAW_W-1:0] raw,
                               input stamp_t now, input logic [IDX_W-1:0] idx);
    sensor_req_t req;
    req.kind = kind;
    req.raw  = raw;
    req.now  = now;
    req.idx  = idx;
    pending_requests_q.push_back(req);
  endtask

  // Blocks until every request has been sent and every report checked.
  task automatic wait_idle();
    while (pending_requests_q.size() != 0 || expected_reports_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic for one register setting. Most samples hold a target
  // pattern long enough to get through the debounce counter, with the odd
  // one-sample glitch; about a quarter are queries, and a few requests are
  // fully random, including wild jumps of the millisecond clock.
  task automatic random_traffic(input int count, input int reads);
    int                k;
    int                sel;
    int                hold;
    logic [RAW_W-1:0]  target;
    logic [RAW_W-1:0]  raw;
    stamp_t            clock_ms;
    hold = 0;
    target = '0;
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                           : $urandom;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      clock_ms += ($urandom_range(0, 99) == 0) ? $urandom : $urandom_range(0, 20);
      if (sel < 8) begin
        queue_request(item_kind_t'($urandom_range(0, 1)), RAW_W'($urandom), $urandom,
                      IDX_W'($urandom));
      end else if (sel < 32) begin
        queue_request(KIND_QUERY, RAW_W'($urandom), clock_ms, IDX_W'($urandom));
      end else begin
        if (hold == 0) begin
          target = RAW_W'($urandom);
          hold = $urandom_range(1, 2 * reads + 4);
        end
        hold--;
        raw = target;
        if ($urandom_range(0, 9) == 0) raw ^= RAW_W'($urandom);
        queue_request(KIND_SAMPLE, raw, clock_ms, IDX_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [MASK_W-1:0] mask, input logic [CNT_W-1:0] reads,
                           input stamp_t timeout, input int count);
    wait_idle();
    write_register(REG_ENABLE_MASK, CFG_DATA_W'(mask));
    write_register(REG_DEBOUNCE_READS, CFG_DATA_W'(reads));
    write_register(REG_MOTION_TIMEOUT, timeout);
    random_traffic(count, (reads == 0) ? 1 : reads);
  endtask

  initial begin : stimulus
    int ch;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: every channel low, timed out against a zero timeout.
    for (ch = 0; ch < CHANNELS; ch++) queue_request(KIND_QUERY, '0, '0, IDX_W'(ch));
    // Three agreeing samples raise all channels with the default debounce count.
    queue_request(KIND_SAMPLE, 4'hF, 32'd100, 2'd0);
    queue_request(KIND_SAMPLE, 4'hF, 32'd101, 2'd1);
    queue_request(KIND_SAMPLE, 4'hF, 32'd102, 2'd2);
    // Duration across the wrap of the millisecond clock, then a second read
    // that must see the rising flag already cleared.
    queue_request(KIND_QUERY, 4'h0, 32'd16, 2'd0);
    queue_request(KIND_QUERY, 4'h0, 32'd150, 2'd0);
    // A single low glitch is forgotten, then three lows drop every channel.
    queue_request(KIND_SAMPLE, 4'h0, 32'd151, 2'd3);
    queue_request(KIND_SAMPLE, 4'hF, 32'd152, 2'd3);
    queue_request(KIND_SAMPLE, 4'h0, 32'd153, 2'd0);
    queue_request(KIND_SAMPLE, 4'h0, 32'd154, 2'd0);
    queue_request(KIND_SAMPLE, 4'h0, 32'd155, 2'd0);
    queue_request(KIND_QUERY, 4'hF, 32'd155, 2'd1);
    wait_idle();

    // Zero debounce count acts as one; channels 1 and 3 disabled.
    write_register(REG_DEBOUNCE_READS, '0);
    write_register(REG_ENABLE_MASK, CFG_DATA_W'(4'b0101));
    write_register(REG_MOTION_TIMEOUT, 32'hFFFF_FFFF);
    queue_request(KIND_SAMPLE, 4'hF, 32'd200, 2'd2);
    // Disabled channels answer from their frozen state.
    queue_request(KIND_QUERY, 4'h0, 32'd300, 2'd1);
    queue_request(KIND_QUERY, 4'h0, 32'd300, 2'd3);
    // Fall at the top of the clock range, then idle times measured from the last
    // sample that saw the channel high, both below the full timeout.
    queue_request(KIND_SAMPLE, 4'h0, 32'hFFFF_FFFF, 2'd0);
    queue_request(KIND_QUERY, 4'hA, 32'd0, 2'd0);
    queue_request(KIND_QUERY, 4'h5, 32'hFFFF_FFFE, 2'd2);

    run_phase(4'hF, 4'd3, 32'd0, 250);
    run_phase(4'hF, 4'd1, 32'd40, 250);
    run_phase(4'h5, 4'd2, 32'd200, 200);
    run_phase(4'hF, 4'd15, 32'd100, 250);
    run_phase(4'hA, 4'd0, 32'hFFFF_FFFF, 200);
    run_phase(4'h0, 4'd4, 32'd10, 100);
    run_phase(MASK_W'($urandom), CNT_W'($urandom_range(1, 15)), $urandom_range(0, 600), 250);
    run_phase(4'hF, 4'd7, $urandom, 150);
    run_phase(4'hF, 4'd2, 32'd60, 200);
    wait_idle();
    repeat (5) @(posedge clk);

    $display("Sent %0d samples and %0d queries across %0d register writes,",
             sample_count, query_count, cfg_count);
    $display("including disabled channels, zero and maximum debounce and clock wrap;");
    $display("%0d reports checked, %0d errors.", checked_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
